// ----- rtl/core/rtp_pkg.sv -----
// Shared constants, types and elaboration-time functions for the rectangular-to-polar unit.
`default_nettype none

package rtp_pkg;

   // Field widths of the channels
   localparam int COEF_W  = 32;
   localparam int AMP_W   = 32;
   localparam int PHASE_W = 16;

   // Datapath formats
   localparam int GUARD_BITS = 8;
   localparam int PATH_W     = COEF_W + GUARD_BITS + 3;
   localparam int ANGLE_W    = 32;
   localparam int GAIN_W     = 30;
   localparam int GAIN_FRAC  = 30;
   localparam int TABLE_LEN  = 32;

   // Parameter defaults
   localparam int DEF_CORDIC_STAGES = 16;
   localparam int DEF_COEF_BITS     = 32;

   // Angle codes: pi, and the half-LSB used when keeping the top phase bits
   localparam logic [ANGLE_W-1:0] ANGLE_PI    = 32'h8000_0000;
   localparam logic [ANGLE_W-1:0] PHASE_ROUND = 32'h0000_8000;

   // round(atan(2^-i) * 2^31 / pi)
   localparam logic [ANGLE_W-1:0] ATAN_TABLE [TABLE_LEN] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
      32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
   };

   // Control bits that travel with each word through the pipeline
   typedef struct packed {
      logic valid;
      logic missing;
      logic zero;
   } tag_type;

   // One finished result word
   typedef struct packed {
      logic [AMP_W-1:0]          amplitude;
      logic signed [PHASE_W-1:0] phase;
      logic                      missing;
   } result_type;

   // Squared CORDIC gain scaled by 2^60
   function automatic logic [63:0] gain_power(input int stages);
      logic [63:0] p;
      p = 64'd1 << 60;
      for (int i = 0; i < TABLE_LEN; i++) begin
         if (i < stages) begin
            p = p + (p >> (2 * i));
         end
      end
      return p;
   endfunction

   // Floor square root of a 64-bit value
   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] rem;
      logic [63:0] res;
      logic [63:0] bitv;
      rem  = v;
      res  = '0;
      bitv = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (rem >= res + bitv) begin
            rem = rem - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rtp_req_if.sv -----
// Request channel: one coefficient pair per word.
`default_nettype none

interface rtp_req_if;
   import rtp_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [COEF_W-1:0] sin_coef;
   logic signed [COEF_W-1:0] cos_coef;
   logic                     coef_missing;

   modport source(output valid, output sin_coef, output cos_coef, output coef_missing,
                  input ready);
   modport sink(input valid, input sin_coef, input cos_coef, input coef_missing,
                output ready);
endinterface

`default_nettype wire

// ----- rtl/core/rtp_rsp_if.sv -----
// Response channel: amplitude and phase of one coefficient pair per word.
`default_nettype none

interface rtp_rsp_if;
   import rtp_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [AMP_W-1:0]          amplitude;
   logic signed [PHASE_W-1:0] phase;
   logic                      result_missing;

   modport source(output valid, output amplitude, output phase, output result_missing,
                  input ready);
   modport sink(input valid, input amplitude, input phase, input result_missing,
                output ready);
endinterface

`default_nettype wire

// ----- rtl/core/rect_to_polar_amplitude_phase_unit.sv -----
// Top level of the pipelined CORDIC rectangular-to-polar unit.
// Usage:
//   req_port carries one coefficient pair per word (sin_coef, cos_coef as signed
//   Q16.16, coef_missing); rsp_port returns amplitude (unsigned Q16.16, gain
//   compensated), phase (-atan2, 32768 = pi) and result_missing.
//   Both channels move a word when valid and ready are high at a clock edge.
//   Each accepted word passes the input fold register, one register per
//   micro-rotation, the two multiply stages and the output register before it
//   shows as rsp valid.
//   Throughput is one word per cycle while the receiver keeps up; every stage is a register with a valid bit.
//   When the receiver stalls, one spare entry behind the output register takes
//   the word in flight, then the whole pipeline holds and req_port.ready drops;
//   req_port.ready comes from a register, never from rsp_port.ready.
//   Missing pairs and pairs with both coefficients zero return zero amplitude
//   and phase. Synchronous reset empties the pipeline and the output entries.
`default_nettype none

module rect_to_polar_amplitude_phase_unit #(
   parameter int CORDIC_STAGES = rtp_pkg::DEF_CORDIC_STAGES,
   parameter int COEF_BITS     = rtp_pkg::DEF_COEF_BITS
) (
   input  logic      clock,
   input  logic      reset,
   rtp_req_if.sink   req_port,
   rtp_rsp_if.source rsp_port
);
   import rtp_pkg::*;

   localparam int SAT_BITS = (COEF_BITS < COEF_W) ? COEF_BITS : COEF_W;
   localparam logic signed [PATH_W-1:0] SAT_MAX = PATH_W'((64'sd1 <<< (SAT_BITS - 1)) - 1);
   localparam logic signed [PATH_W-1:0] SAT_MIN = -SAT_MAX - PATH_W'(1);

   logic                     advance;
   logic signed [PATH_W-1:0] s_ext, c_ext, s_sat, c_sat, s_scl, c_scl;
   logic signed [PATH_W-1:0] x_in, y_in;
   logic [ANGLE_W-1:0]       z_in;
   tag_type                  tag_in;
   logic signed [PATH_W-1:0] x_ff, y_ff;
   logic [ANGLE_W-1:0]       z_ff;
   tag_type                  tag_ff;

   tag_type                  tag_pipe [CORDIC_STAGES+1];
   logic signed [PATH_W-1:0] x_pipe   [CORDIC_STAGES+1];
   logic signed [PATH_W-1:0] y_pipe   [CORDIC_STAGES+1];
   logic [ANGLE_W-1:0]       z_pipe   [CORDIC_STAGES+1];

   logic       fin_valid;
   result_type fin_word;
   result_type out_word;

   assign req_port.ready = advance;

   // Saturate, add guard bits and fold into the right half-plane
   always_comb begin
      s_ext = PATH_W'(req_port.sin_coef);
      c_ext = PATH_W'(req_port.cos_coef);
      s_sat = (s_ext > SAT_MAX) ? SAT_MAX : ((s_ext < SAT_MIN) ? SAT_MIN : s_ext);
      c_sat = (c_ext > SAT_MAX) ? SAT_MAX : ((c_ext < SAT_MIN) ? SAT_MIN : c_ext);
      s_scl = s_sat <<< GUARD_BITS;
      c_scl = c_sat <<< GUARD_BITS;
      if (c_scl[PATH_W-1]) begin
         x_in = -c_scl;
         y_in = -s_scl;
         z_in = ANGLE_PI;
      end else begin
         x_in = c_scl;
         y_in = s_scl;
         z_in = '0;
      end
      tag_in.valid   = req_port.valid;
      tag_in.missing = req_port.coef_missing;
      tag_in.zero    = (s_ext == '0) && (c_ext == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else if (advance) begin
         tag_ff <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign tag_pipe[0] = tag_ff;
   assign x_pipe[0]   = x_ff;
   assign y_pipe[0]   = y_ff;
   assign z_pipe[0]   = z_ff;

   // One register stage per micro-rotation
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      rtp_cordic_stage #(
         .SHIFT (i),
         .ANGLE (ATAN_TABLE[i])
      ) u_stage (
         .clock  (clock),
         .reset  (reset),
         .enable (advance),
         .tag_i  (tag_pipe[i]),
         .x_i    (x_pipe[i]),
         .y_i    (y_pipe[i]),
         .z_i    (z_pipe[i]),
         .tag_o  (tag_pipe[i+1]),
         .x_o    (x_pipe[i+1]),
         .y_o    (y_pipe[i+1]),
         .z_o    (z_pipe[i+1])
      );
   end

   rtp_gain_mul #(
      .CORDIC_STAGES (CORDIC_STAGES)
   ) u_gain (
      .clock    (clock),
      .reset    (reset),
      .enable   (advance),
      .tag_i    (tag_pipe[CORDIC_STAGES]),
      .x_i      (x_pipe[CORDIC_STAGES]),
      .z_i      (z_pipe[CORDIC_STAGES]),
      .valid_o  (fin_valid),
      .result_o (fin_word)
   );

   rtp_out_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fin_valid),
      .in_word   (fin_word),
      .advance   (advance),
      .out_valid (rsp_port.valid),
      .out_word  (out_word),
      .out_ready (rsp_port.ready)
   );

   assign rsp_port.amplitude      = out_word.amplitude;
   assign rsp_port.phase          = out_word.phase;
   assign rsp_port.result_missing = out_word.missing;

endmodule

`default_nettype wire

// ----- rtl/core/rtp_cordic_stage.sv -----
// One registered CORDIC vectoring micro-rotation.
`default_nettype none

module rtp_cordic_stage #(
   parameter int                      SHIFT = 0,
   parameter logic [rtp_pkg::ANGLE_W-1:0] ANGLE = '0
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                enable,
   input  rtp_pkg::tag_type                    tag_i,
   input  logic signed [rtp_pkg::PATH_W-1:0]  x_i,
   input  logic signed [rtp_pkg::PATH_W-1:0]  y_i,
   input  logic [rtp_pkg::ANGLE_W-1:0]        z_i,
   output rtp_pkg::tag_type                    tag_o,
   output logic signed [rtp_pkg::PATH_W-1:0]  x_o,
   output logic signed [rtp_pkg::PATH_W-1:0]  y_o,
   output logic [rtp_pkg::ANGLE_W-1:0]        z_o
);
   import rtp_pkg::*;

   logic signed [PATH_W-1:0] x_shift;
   logic signed [PATH_W-1:0] y_shift;
   logic signed [PATH_W-1:0] x_in, y_in;
   logic [ANGLE_W-1:0]       z_in;
   logic signed [PATH_W-1:0] x_ff, y_ff;
   logic [ANGLE_W-1:0]       z_ff;
   tag_type                  tag_ff;

   // Rotate toward the x axis, direction set by the sign of y
   always_comb begin
      x_shift = x_i >>> SHIFT;
      y_shift = y_i >>> SHIFT;
      if (!y_i[PATH_W-1]) begin
         x_in = x_i + y_shift;
         y_in = y_i - x_shift;
         z_in = z_i + ANGLE;
      end else begin
         x_in = x_i - y_shift;
         y_in = y_i + x_shift;
         z_in = z_i - ANGLE;
      end
   end

   // Advance the word when the pipeline moves, hold otherwise
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else if (enable) begin
         tag_ff <= tag_i;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign tag_o = tag_ff;
   assign x_o   = x_ff;
   assign y_o   = y_ff;
   assign z_o   = z_ff;

endmodule

`default_nettype wire

// ----- rtl/core/rtp_gain_mul.sv -----
// Gain compensation multiply, rounding, saturation and phase output.
`default_nettype none

module rtp_gain_mul #(
   parameter int CORDIC_STAGES = rtp_pkg::DEF_CORDIC_STAGES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                enable,
   input  rtp_pkg::tag_type                    tag_i,
   input  logic signed [rtp_pkg::PATH_W-1:0]  x_i,
   input  logic [rtp_pkg::ANGLE_W-1:0]        z_i,
   output logic                                valid_o,
   output rtp_pkg::result_type                 result_o
);
   import rtp_pkg::*;

   // Inverse gain G = round(2^60 / isqrt(P))
   localparam logic [63:0] GAIN_P    = gain_power(CORDIC_STAGES);
   localparam logic [63:0] GAIN_K    = isqrt64(GAIN_P);
   localparam logic [63:0] GAIN_FULL = ((64'd1 << 60) + (GAIN_K >> 1)) / GAIN_K;
   localparam logic [GAIN_W-1:0] GAIN = GAIN_W'(GAIN_FULL);

   localparam int A_W    = PATH_W - 1;
   localparam int LO_W   = A_W / 2;
   localparam int HI_W   = A_W - LO_W;
   localparam int PROD_W = A_W + GAIN_W;
   localparam int T1_W   = PROD_W - GAIN_FRAC;
   localparam int T2_W   = T1_W + 1 - GUARD_BITS;
   localparam logic [PROD_W-1:0] MUL_ROUND   = PROD_W'(1) << (GAIN_FRAC - 1);
   localparam logic [T1_W:0]     GUARD_ROUND = (T1_W + 1)'(1) << (GUARD_BITS - 1);

   logic [A_W-1:0]          mag;
   logic [LO_W+GAIN_W-1:0]  prod_lo_in, prod_lo_ff;
   logic [HI_W+GAIN_W-1:0]  prod_hi_in, prod_hi_ff;
   logic [ANGLE_W-1:0]      z1_ff, z2_ff;
   tag_type                 tag1_ff, tag2_ff;
   logic [PROD_W-1:0]       prod_sum;
   logic [T1_W-1:0]         t1_in, t1_ff;
   logic [T1_W:0]           t1_round;
   logic [T2_W-1:0]         t2;
   logic [ANGLE_W-1:0]      phase_full;

   // Stage one: two partial products of the magnitude by the gain
   always_comb begin
      mag        = x_i[PATH_W-1] ? '0 : x_i[A_W-1:0];
      prod_lo_in = (LO_W+GAIN_W)'(mag[LO_W-1:0]) * (LO_W+GAIN_W)'(GAIN);
      prod_hi_in = (HI_W+GAIN_W)'(mag[A_W-1:LO_W]) * (HI_W+GAIN_W)'(GAIN);
   end

   // Stage two: combine partial products, drop the gain fraction rounded half up
   always_comb begin
      prod_sum = (PROD_W'(prod_hi_ff) << LO_W) + PROD_W'(prod_lo_ff) + MUL_ROUND;
      t1_in    = prod_sum[PROD_W-1:GAIN_FRAC];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
      end else if (enable) begin
         tag1_ff <= tag_i;
         tag2_ff <= tag1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_lo_ff <= prod_lo_in;
         prod_hi_ff <= prod_hi_in;
         z1_ff      <= z_i;
         t1_ff      <= t1_in;
         z2_ff      <= z1_ff;
      end
   end

   // Finish: drop guard bits, saturate, negate the angle and keep its top bits
   always_comb begin
      t1_round   = (T1_W + 1)'(t1_ff) + GUARD_ROUND;
      t2         = t1_round[T1_W:GUARD_BITS];
      phase_full = (ANGLE_W'(0) - z2_ff) + PHASE_ROUND;
      result_o.missing = tag2_ff.missing;
      if (tag2_ff.missing || tag2_ff.zero) begin
         result_o.amplitude = '0;
         result_o.phase     = '0;
      end else begin
         result_o.amplitude = (|t2[T2_W-1:AMP_W]) ? '1 : t2[AMP_W-1:0];
         result_o.phase     = phase_full[ANGLE_W-1:ANGLE_W-PHASE_W];
      end
   end

   assign valid_o = tag2_ff.valid;

endmodule

`default_nettype wire

// ----- rtl/core/rtp_out_skid.sv -----
// Output register with a spare entry so the pipeline stall is driven from registers.
`default_nettype none

module rtp_out_skid (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  rtp_pkg::result_type in_word,
   output logic                advance,
   output logic                out_valid,
   output rtp_pkg::result_type out_word,
   input  logic                out_ready
);
   import rtp_pkg::*;

   logic       main_valid_ff, main_valid_in;
   logic       spare_valid_ff, spare_valid_in;
   result_type main_ff, main_in;
   result_type spare_ff, spare_in;
   logic       push, pop;

   // Pipeline moves only while the spare entry is free
   assign advance = !spare_valid_ff;
   assign push    = advance && in_valid;
   assign pop     = main_valid_ff && out_ready;

   always_comb begin
      main_valid_in  = main_valid_ff;
      spare_valid_in = spare_valid_ff;
      main_in        = main_ff;
      spare_in       = spare_ff;
      if (spare_valid_ff) begin
         // drain the spare into the output register
         if (pop) begin
            main_in        = spare_ff;
            spare_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_in       = in_word;
            main_valid_in = 1'b1;
         end else begin
            spare_in       = in_word;
            spare_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff  <= 1'b0;
         spare_valid_ff <= 1'b0;
      end else begin
         main_valid_ff  <= main_valid_in;
         spare_valid_ff <= spare_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff  <= main_in;
      spare_ff <= spare_in;
   end

   assign out_valid = main_valid_ff;
   assign out_word  = main_ff;

endmodule

`default_nettype wire

// ----- dv/tb_rect_to_polar_amplitude_phase_unit.sv -----
// Self-checking testbench for the CORDIC rectangular-to-polar unit: directed and random pairs.
`timescale 1ns / 100ps

module tb_rect_to_polar_amplitude_phase_unit;
   import rtp_pkg::*;

   localparam int          STAGES     = DEF_CORDIC_STAGES;
   localparam int          COEF_LIMIT = DEF_COEF_BITS;
   localparam int unsigned CYCLE_CAP  = 200000;
   localparam int unsigned LONG_HOLD  = 160;
   localparam int unsigned HOLD_AFTER = 150;
   localparam int          RANDOM_PAIRS = 450;

   // One coefficient pair waiting to go out; drain makes the sender wait for all results
   typedef struct {
      logic [COEF_W-1:0] sin_val;
      logic [COEF_W-1:0] cos_val;
      logic              miss;
      logic              drain;
   } coef_pair_type;

   logic clock;
   logic reset;

   rtp_req_if req_chan();
   rtp_rsp_if rsp_chan();

   rect_to_polar_amplitude_phase_unit #(
      .CORDIC_STAGES(STAGES),
      .COEF_BITS    (COEF_LIMIT)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_port(req_chan),
      .rsp_port(rsp_chan)
   );

   coef_pair_type pair_queue[$];
   result_type    polar_due[$];
   int unsigned pairs_sent;
   int unsigned polars_seen;
   int unsigned fail_count;
   int unsigned cycle_count;
   int unsigned drv_gap_left;
   int unsigned drv_calm;
   int unsigned rcv_hold_left;
   int unsigned rcv_calm;
   int unsigned long_hold_left;
   logic        long_hold_done;

   // Clamp a coefficient to the configured signed width
   function automatic longint clamp_coef(longint v);
      longint lim;
      if (COEF_LIMIT >= 33) return v;
      lim = longint'(1) <<< (COEF_LIMIT - 1);
      if (v > lim - 1) return lim - 1;
      if (v < -lim) return -lim;
      return v;
   endfunction

   // Inverse CORDIC gain scaled by 2^30, from the floor root of the squared gain
   function automatic longint unsigned inv_gain();
      longint unsigned pw;
      longint unsigned root;
      longint unsigned cand;
      pw   = 64'd1 << 60;
      root = 0;
      for (int i = 0; i < STAGES && i < TABLE_LEN; i++) begin
         pw = pw + (pw >> (2 * i));
      end
      for (int b = 31; b >= 0; b--) begin
         cand = root | (64'd1 << b);
         if (cand * cand <= pw) root = cand;
      end
      if (root == 0) return 0;
      return ((64'd1 << 60) + (root >> 1)) / root;
   endfunction

   // Amplitude and phase of one pair, as the unit should return them
   function automatic result_type polar_of(logic [COEF_W-1:0] s_raw, logic [COEF_W-1:0] c_raw,
                                           logic miss);
      result_type      r;
      longint          sv, cv, x, y, nx, ny;
      logic [31:0]     ang;
      logic [31:0]     ph_sum;
      longint unsigned mag, g, hi, lo, t;
      r         = '0;
      r.missing = miss;
      if (miss) return r;
      sv = clamp_coef(longint'($signed(s_raw)));
      cv = clamp_coef(longint'($signed(c_raw)));
      if (sv == 0 && cv == 0) return r;
      x   = cv <<< GUARD_BITS;
      y   = sv <<< GUARD_BITS;
      ang = '0;
      // fold into the right half-plane
      if (x < 0) begin
         x   = -x;
         y   = -y;
         ang = ANGLE_PI;
      end
      // vectoring micro-rotations drive y toward zero
      for (int i = 0; i < STAGES && i < TABLE_LEN; i++) begin
         if (y >= 0) begin
            nx  = x + (y >>> i);
            ny  = y - (x >>> i);
            ang = ang + ATAN_TABLE[i];
         end else begin
            nx  = x - (y >>> i);
            ny  = y + (x >>> i);
            ang = ang - ATAN_TABLE[i];
         end
         x = nx;
         y = ny;
      end
      // gain removal, then guard bits off, both rounded half up
      mag = (x < 0) ? 64'd0 : longint'(x);
      g   = inv_gain();
      hi  = mag >> 30;
      lo  = mag & 64'h3FFF_FFFF;
      t   = hi * g + ((lo * g + (64'd1 << 29)) >> 30);
      t   = (t + (64'd1 << (GUARD_BITS - 1))) >> GUARD_BITS;
      if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
      r.amplitude = t[31:0];
      ph_sum      = (32'd0 - ang) + PHASE_ROUND;
      r.phase     = ph_sum[31:16];
      return r;
   endfunction

   // Random idle length: mostly none, some short, a few long, with calm stretches
   function automatic int unsigned pick_gap(inout int unsigned calm);
      int unsigned r;
      if (calm != 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 199);
      if (r < 3) begin
         calm = $urandom_range(30, 90);
         return 0;
      end
      if (r < 110) return 0;
      if (r < 170) return $urandom_range(1, 3);
      if (r < 192) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      fail_count++;
   endtask

   task automatic add_pair(input logic [COEF_W-1:0] s, input logic [COEF_W-1:0] c,
                           input logic miss, input logic drain);
      coef_pair_type p;
      p.sin_val = s;
      p.cos_val = c;
      p.miss    = miss;
      p.drain   = drain;
      pair_queue.push_back(p);
   endtask

   // Random coefficient: full range, small, shifted down, or an extreme
   function automatic logic [COEF_W-1:0] rand_coef();
      logic signed [COEF_W-1:0] w;
      w = $urandom;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return w;
         4, 5:       return w >>> $urandom_range(16, 30);
         6, 7:       return w >>> $urandom_range(1, 15);
         default: begin
            case ($urandom_range(0, 4))
               0:       return 32'h7FFF_FFFF;
               1:       return 32'h8000_0000;
               2:       return 32'h0000_0001;
               3:       return 32'hFFFF_FFFF;
               default: return 32'h0000_0000;
            endcase
         end
      endcase
   endfunction

   // Clock, and known levels on every input from time zero
   initial begin
      clock                 = 1'b0;
      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.sin_coef     = '0;
      req_chan.cos_coef     = '0;
      req_chan.coef_missing = 1'b0;
      rsp_chan.ready        = 1'b0;
      forever #6 clock = ~clock;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_CAP) begin
         $display("[rect_to_polar_amplitude_phase_unit] ERROR");
         $finish;
      end
   end

   // Driver: offer pending words, hold while stalled, idle between words
   always @(posedge clock) begin : drive_req
      logic fired;
      fired = req_chan.valid && req_chan.ready;
      if (reset) begin
         req_chan.valid        <= 1'b0;
         req_chan.sin_coef     <= '0;
         req_chan.cos_coef     <= '0;
         req_chan.coef_missing <= 1'b0;
         drv_gap_left          <= 0;
      end else begin
         if (fired) begin
            polar_due.push_back(polar_of(req_chan.sin_coef, req_chan.cos_coef,
                                         req_chan.coef_missing));
            pairs_sent <= pairs_sent + 1;
         end
         if (!req_chan.valid || fired) begin
            if (drv_gap_left != 0) begin
               drv_gap_left   <= drv_gap_left - 1;
               req_chan.valid <= 1'b0;
            end else if (pair_queue.size() != 0 &&
                         (!pair_queue[0].drain ||
                          (pairs_sent + (fired ? 1 : 0) == polars_seen))) begin
               req_chan.sin_coef     <= pair_queue[0].sin_val;
               req_chan.cos_coef     <= pair_queue[0].cos_val;
               req_chan.coef_missing <= pair_queue[0].miss;
               req_chan.valid        <= 1'b1;
               void'(pair_queue.pop_front());
               drv_gap_left <= (long_hold_left != 0) ? 0 : pick_gap(drv_calm);
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off once traffic is going
   always @(posedge clock) begin : drive_rsp_ready
      int unsigned hold;
      hold = 0;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rcv_hold_left  <= 0;
         long_hold_left <= 0;
         long_hold_done <= 1'b0;
      end else if (long_hold_left != 0) begin
         long_hold_left <= long_hold_left - 1;
         rsp_chan.ready <= 1'b0;
      end else if (!long_hold_done && pairs_sent >= HOLD_AFTER) begin
         long_hold_left <= LONG_HOLD;
         long_hold_done <= 1'b1;
         rsp_chan.ready <= 1'b0;
      end else if (rcv_hold_left != 0) begin
         rcv_hold_left  <= rcv_hold_left - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         if ($urandom_range(0, 3) == 0) hold = pick_gap(rcv_calm);
         if (hold != 0) begin
            rcv_hold_left  <= hold - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Monitor: compare each accepted word with the oldest expected result
   always @(posedge clock) begin : check_rsp
      result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         polars_seen <= polars_seen + 1;
         if (polar_due.size() == 0) begin
            report_mismatch($sformatf("result word %0d with nothing expected", polars_seen));
         end else begin
            want = polar_due.pop_front();
            if (rsp_chan.amplitude !== want.amplitude)
               report_mismatch($sformatf("word %0d amplitude got %h want %h", polars_seen,
                                         rsp_chan.amplitude, want.amplitude));
            if (rsp_chan.phase !== want.phase)
               report_mismatch($sformatf("word %0d phase got %0d want %0d", polars_seen,
                                         rsp_chan.phase, want.phase));
            if (rsp_chan.result_missing !== want.missing)
               report_mismatch($sformatf("word %0d result_missing got %b want %b", polars_seen,
                                         rsp_chan.result_missing, want.missing));
         end
      end
   end

   // Stimulus and end of run
   initial begin : stimulus
      int unsigned kind;
      logic [COEF_W-1:0] s, c;
      pairs_sent  = 0;
      polars_seen = 0;
      fail_count  = 0;
      cycle_count = 0;
      drv_calm    = 0;
      rcv_calm    = 0;

      // directed: zeros, missing pairs, axes, extremes
      add_pair(32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0);
      add_pair(32'h1234_5678, 32'h8765_4321, 1'b1, 1'b0);
      add_pair(32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0);
      add_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
      add_pair(32'h0000_0000, 32'h8000_0000, 1'b0, 1'b0);
      add_pair(32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0);
      add_pair(32'h0000_0000, 32'hFFFF_0000, 1'b0, 1'b0);
      add_pair(32'h0000_0000, 32'h0001_0000, 1'b0, 1'b0);
      add_pair(32'h0001_0000, 32'h0000_0000, 1'b0, 1'b0);
      add_pair(32'hFFFF_0000, 32'h0000_0000, 1'b0, 1'b0);
      add_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0);
      add_pair(32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0);
      add_pair(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0);
      add_pair(32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0);
      add_pair(32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 1'b0);
      add_pair(32'h0000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0);
      add_pair(32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0);
      add_pair(32'h0000_0001, 32'h0000_0000, 1'b0, 1'b0);
      add_pair(32'h0000_0000, 32'h0000_0001, 1'b0, 1'b0);
      add_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0);
      add_pair(32'h0000_0001, 32'hFFFF_FFFF, 1'b0, 1'b0);
      add_pair(32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 1'b0);
      add_pair(32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b1);

      // random pairs; one in the middle waits for the unit to drain
      for (int n = 0; n < RANDOM_PAIRS; n++) begin
         kind = $urandom_range(0, 19);
         s    = rand_coef();
         c    = rand_coef();
         if (kind < 2) begin
            add_pair(s, c, 1'b1, 1'b0);
         end else if (kind == 2) begin
            add_pair(32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0);
         end else if (kind < 5) begin
            if (kind == 3) s = '0;
            else c = '0;
            add_pair(s, c, 1'b0, 1'b0);
         end else begin
            add_pair(s, c, 1'b0, n == 300);
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // wait for all words out, then for their results, then check that none are still due
      while (pair_queue.size() != 0 || req_chan.valid) @(posedge clock);
      while (pairs_sent != polars_seen) @(posedge clock);
      repeat (STAGES + 14) @(posedge clock);
      if (polar_due.size() != 0)
         report_mismatch($sformatf("%0d expected results never came", polar_due.size()));

      if (fail_count == 0) begin
         $display("[rect_to_polar_amplitude_phase_unit] OK");
      end else begin
         $display("[rect_to_polar_amplitude_phase_unit] ERROR");
      end
      $finish;
   end

endmodule
